// ----- sv/cpf_pkg.sv -----
// Shared constants and register index codes for the colour perception pixel filter.
package cpf_pkg;

    localparam int unsigned CHANNEL_BITS     = 8;
    localparam int unsigned WEIGHT_FRAC_BITS = 8;
    localparam int unsigned NUM_REGS         = 6;
    localparam int unsigned REG_IDX_BITS     = 3;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_W_R  = 3'd0,
        REG_W_G  = 3'd1,
        REG_W_B  = 3'd2,
        REG_W_RG = 3'd3,
        REG_W_RB = 3'd4,
        REG_W_GB = 3'd5
    } t_reg_idx;

endpackage

// ----- sv/cpf_in_if.sv -----
// Input pixel channel: valid/ready handshake with one RGB item.
interface cpf_in_if #(
    parameter int unsigned CB = cpf_pkg::CHANNEL_BITS
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] in_red;
    logic [CB-1:0] in_green;
    logic [CB-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

// ----- sv/cpf_out_if.sv -----
// Output pixel channel: valid/ready handshake with one perceived RGB item.
interface cpf_out_if #(
    parameter int unsigned CB = cpf_pkg::CHANNEL_BITS
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] out_red;
    logic [CB-1:0] out_green;
    logic [CB-1:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

// ----- sv/cpf_weigh.sv -----
// Channel ranking, weighted primary/secondary products and remaining light.
module cpf_weigh #(
    parameter int unsigned CB = cpf_pkg::CHANNEL_BITS,
    parameter int unsigned FB = cpf_pkg::WEIGHT_FRAC_BITS
) (
    input  logic [CB-1:0]                            i_red,
    input  logic [CB-1:0]                            i_green,
    input  logic [CB-1:0]                            i_blue,
    input  logic [cpf_pkg::NUM_REGS-1:0][FB:0]       i_weight,
    output logic [CB+1:0]                            o_acc_red,
    output logic [CB+1:0]                            o_acc_green,
    output logic [CB+1:0]                            o_acc_blue,
    output logic [CB+1:0]                            o_rem
);

    logic [2:0]       dom_oh;
    logic [2:0]       mid_oh;
    logic [CB-1:0]    dom_v;
    logic [CB-1:0]    mid_v;
    logic [CB-1:0]    low_v;
    logic [FB:0]      wp;
    logic [FB:0]      ws;
    logic [CB+FB:0]   prod_p;
    logic [CB+FB:0]   prod_s;
    logic [CB:0]      primary;
    logic [CB:0]      secondary;
    logic [CB+1:0]    both;
    logic [CB+2:0]    spent;
    logic [CB+2:0]    total;

    // Rank channels; an earlier-tested channel wins a tie.
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            dom_oh = 3'b001;
            dom_v  = i_red;
            wp     = i_weight[cpf_pkg::REG_W_R];
            if (i_green >= i_blue) begin
                mid_oh = 3'b010; mid_v = i_green; low_v = i_blue;
                ws     = i_weight[cpf_pkg::REG_W_RG];
            end else begin
                mid_oh = 3'b100; mid_v = i_blue; low_v = i_green;
                ws     = i_weight[cpf_pkg::REG_W_RB];
            end
        end else if (i_green >= i_blue) begin
            dom_oh = 3'b010;
            dom_v  = i_green;
            wp     = i_weight[cpf_pkg::REG_W_G];
            if (i_red >= i_blue) begin
                mid_oh = 3'b001; mid_v = i_red; low_v = i_blue;
                ws     = i_weight[cpf_pkg::REG_W_RG];
            end else begin
                mid_oh = 3'b100; mid_v = i_blue; low_v = i_red;
                ws     = i_weight[cpf_pkg::REG_W_GB];
            end
        end else begin
            dom_oh = 3'b100;
            dom_v  = i_blue;
            wp     = i_weight[cpf_pkg::REG_W_B];
            if (i_red >= i_green) begin
                mid_oh = 3'b001; mid_v = i_red; low_v = i_green;
                ws     = i_weight[cpf_pkg::REG_W_RB];
            end else begin
                mid_oh = 3'b010; mid_v = i_green; low_v = i_red;
                ws     = i_weight[cpf_pkg::REG_W_GB];
            end
        end
    end

    // Truncate products by dropping the fraction bits.
    assign prod_p    = (CB+FB+1)'(dom_v - mid_v) * (CB+FB+1)'(wp);
    assign prod_s    = (CB+FB+1)'(mid_v - low_v) * (CB+FB+1)'(ws);
    assign primary   = prod_p[CB+FB:FB];
    assign secondary = prod_s[CB+FB:FB];
    assign both      = (CB+2)'(primary) + (CB+2)'(secondary);

    assign spent = (CB+3)'(primary) + {1'b0, secondary, 1'b0};
    assign total = (CB+3)'(i_red) + (CB+3)'(i_green) + (CB+3)'(i_blue);

    // Clamp negative remaining light to zero.
    assign o_rem = (total > spent) ? (CB+2)'(total - spent) : '0;

    always_comb begin
        o_acc_red   = dom_oh[0] ? both : (mid_oh[0] ? (CB+2)'(secondary) : '0);
        o_acc_green = dom_oh[1] ? both : (mid_oh[1] ? (CB+2)'(secondary) : '0);
        o_acc_blue  = dom_oh[2] ? both : (mid_oh[2] ? (CB+2)'(secondary) : '0);
    end

endmodule

// ----- sv/cpf_mix.sv -----
// White share by reciprocal multiply, added to each channel with saturation.
module cpf_mix #(
    parameter int unsigned CB = cpf_pkg::CHANNEL_BITS
) (
    input  logic [CB+1:0] i_acc_red,
    input  logic [CB+1:0] i_acc_green,
    input  logic [CB+1:0] i_acc_blue,
    input  logic [CB+1:0] i_rem,
    output logic [CB-1:0] o_red,
    output logic [CB-1:0] o_green,
    output logic [CB-1:0] o_blue
);

    // Exact floor(x/3) for x below 2^(CB+2): multiply by ceil(2^(CB+3)/3), shift.
    localparam int unsigned DivShift = CB + 3;
    localparam logic [CB+1:0] DivMul =
        (CB+2)'(((64'd1 << DivShift) + 64'd2) / 64'd3);

    logic [2*CB+3:0] prod;
    logic [CB-1:0]   white;
    logic [CB+2:0]   sum_r;
    logic [CB+2:0]   sum_g;
    logic [CB+2:0]   sum_b;

    assign prod  = (2*CB+4)'(i_rem) * (2*CB+4)'(DivMul);
    assign white = prod[DivShift +: CB];

    assign sum_r = (CB+3)'(i_acc_red)   + (CB+3)'(white);
    assign sum_g = (CB+3)'(i_acc_green) + (CB+3)'(white);
    assign sum_b = (CB+3)'(i_acc_blue)  + (CB+3)'(white);

    assign o_red   = (|sum_r[CB+2:CB]) ? '1 : sum_r[CB-1:0];
    assign o_green = (|sum_g[CB+2:CB]) ? '1 : sum_g[CB-1:0];
    assign o_blue  = (|sum_b[CB+2:CB]) ? '1 : sum_b[CB-1:0];

endmodule

// ----- sv/colour_perception_pixel_filter.sv -----
// Top level of the colour perception pixel filter: weights, pipeline and handshake.
// An accepted item passes the input, products and result registers before it shows on o_out.
// Throughput: one item per cycle while o_out is ready; three register stages (input,
//   products, result) each take a new item when empty or when their downstream stage moves.
// Reset (i_rst_n low, synchronous): all stages empty, all six weights back to 1.0.
// Configuration writes take effect at the next edge; write only while the block is idle.
module colour_perception_pixel_filter #(
    parameter int unsigned CHANNEL_BITS     = cpf_pkg::CHANNEL_BITS,
    parameter int unsigned WEIGHT_FRAC_BITS = cpf_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpf_pkg::REG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [WEIGHT_FRAC_BITS:0]           i_cfg_data,
    cpf_in_if.sink                              i_in,
    cpf_out_if.source                           o_out
);

    localparam int unsigned CB = CHANNEL_BITS;
    localparam int unsigned FB = WEIGHT_FRAC_BITS;
    localparam logic [FB:0] WeightOne = {1'b1, {FB{1'b0}}};

    // Weight registers, one per configuration index.
    logic [cpf_pkg::NUM_REGS-1:0][FB:0] r_weight;

    // Stage 1: captured pixel.
    logic          r_v1;
    logic [CB-1:0] r_red;
    logic [CB-1:0] r_green;
    logic [CB-1:0] r_blue;

    // Stage 2: per-channel accumulations and remaining light.
    logic          r_v2;
    logic [CB+1:0] r_acc_red;
    logic [CB+1:0] r_acc_green;
    logic [CB+1:0] r_acc_blue;
    logic [CB+1:0] r_rem;

    // Stage 3: result register.
    logic          r_v3;
    logic [CB-1:0] r_out_red;
    logic [CB-1:0] r_out_green;
    logic [CB-1:0] r_out_blue;

    logic          en1;
    logic          en2;
    logic          en3;
    logic          in_acc;
    logic          out_acc;

    logic [CB+1:0] n_acc_red;
    logic [CB+1:0] n_acc_green;
    logic [CB+1:0] n_acc_blue;
    logic [CB+1:0] n_rem;
    logic [CB-1:0] n_out_red;
    logic [CB-1:0] n_out_green;
    logic [CB-1:0] n_out_blue;

    // Each stage loads when it is empty or the stage after it loads; bubbles collapse,
    // so a waiting result never blocks new items while earlier stages have room.
    assign en3     = !r_v3 || o_out.ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign in_acc  = i_in.valid && en1;
    assign out_acc = r_v3 && o_out.ready;

    assign i_in.ready      = en1;
    assign o_out.valid     = r_v3;
    assign o_out.out_red   = r_out_red;
    assign o_out.out_green = r_out_green;
    assign o_out.out_blue  = r_out_blue;

    // Store the weight on a write; drop writes to an unknown index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= {cpf_pkg::NUM_REGS{WeightOne}};
        end else if (i_cfg_we && i_cfg_idx < cpf_pkg::REG_IDX_BITS'(cpf_pkg::NUM_REGS)) begin
            r_weight[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers: advance with their stage, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= i_in.in_red;
            r_green <= i_in.in_green;
            r_blue  <= i_in.in_blue;
        end
        if (en2 && r_v1) begin
            r_acc_red   <= n_acc_red;
            r_acc_green <= n_acc_green;
            r_acc_blue  <= n_acc_blue;
            r_rem       <= n_rem;
        end
        if (en3 && r_v2) begin
            r_out_red   <= n_out_red;
            r_out_green <= n_out_green;
            r_out_blue  <= n_out_blue;
        end
    end

    cpf_weigh #(
        .CB (CB),
        .FB (FB)
    ) u_weigh (
        .i_red       (r_red),
        .i_green     (r_green),
        .i_blue      (r_blue),
        .i_weight    (r_weight),
        .o_acc_red   (n_acc_red),
        .o_acc_green (n_acc_green),
        .o_acc_blue  (n_acc_blue),
        .o_rem       (n_rem)
    );

    cpf_mix #(
        .CB (CB)
    ) u_mix (
        .i_acc_red   (r_acc_red),
        .i_acc_green (r_acc_green),
        .i_acc_blue  (r_acc_blue),
        .i_rem       (r_rem),
        .o_red       (n_out_red),
        .o_green     (n_out_green),
        .o_blue      (n_out_blue)
    );

    // Items in flight grow by one when one enters and none leaves.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !out_acc) |=>
        ($countones({r_v1, r_v2, r_v3}) == $past($countones({r_v1, r_v2, r_v3})) + 1))
        else $error("item count did not grow on accept");

    // Items in flight shrink by one when one leaves and none enters.
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !in_acc) |=>
        ($countones({r_v1, r_v2, r_v3}) + 1 == $past($countones({r_v1, r_v2, r_v3}))))
        else $error("item count did not shrink on delivery");

    // Writes to an unknown index leave every weight untouched.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx >= cpf_pkg::REG_IDX_BITS'(cpf_pkg::NUM_REGS)) |=>
        $stable(r_weight))
        else $error("weight changed on write to unknown index");

    // Reset brings every weight back to 1.0.
    a_reset_weight: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_weight == {cpf_pkg::NUM_REGS{WeightOne}}))
        else $error("weights not at 1.0 after reset");

endmodule
